/* design/rotation_matrix_to_quaternion_assert.svh */
// Assertion macros shared by the rotation-matrix-to-quaternion RTL.
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RMQ_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define RMQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/rmq_pkg.sv */
// Constants, branch codes and saturation helper for the quaternion pipeline.
`default_nettype none
package rmq_pkg;

  localparam int DW        = 16;
  localparam int FRAC_BITS = 14;

  // signed width of the square-root argument
  localparam int AW_BASE = (DW > FRAC_BITS + 1) ? DW : FRAC_BITS + 1;
  localparam int ARG_W   = AW_BASE + 3;
  // radicand = arg << FRAC_BITS, rounded up to an even width
  localparam int RAD_RAW = ARG_W - 1 + FRAC_BITS;
  localparam int RAD_W   = RAD_RAW + (RAD_RAW % 2);
  localparam int ROOT_W  = RAD_W / 2;
  localparam int S_W     = ROOT_W + 1;
  // numerator magnitude: a sum of two DW-bit fields can reach 2^DW
  localparam int MAG_W   = DW + 1;
  // dividend magnitude = |d| << FRAC_BITS
  localparam int NUM_W   = MAG_W + FRAC_BITS;

  typedef enum logic [3:0] {
    BR_TRACE = 4'b0001,
    BR_X     = 4'b0010,
    BR_Y     = 4'b0100,
    BR_Z     = 4'b1000
  } branch_t;

  // Apply sign to a magnitude and clamp to the DW-bit signed range.
  function automatic logic [DW-1:0] sat_mag(input logic [NUM_W-1:0] mag, input logic neg);
    logic [NUM_W-1:0] lim;
    logic [NUM_W-1:0] negv;
    lim  = NUM_W'(1) << (DW - 1);
    negv = ~mag + NUM_W'(1);
    if (!neg) begin
      return (mag >= lim) ? DW'(lim - NUM_W'(1)) : mag[DW-1:0];
    end else begin
      return (mag >= lim) ? lim[DW-1:0] : negv[DW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* design/rotation_matrix_to_quaternion.sv */
// Top level: 3x3 rotation matrix (Q1.14) to unit quaternion, Shepperd's method, pipelined.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------
//   in      | to block  | in_valid / in_ready | m11 m12 m13 m21 m22 m23 m31 m32 m33
//   out     | from block| out_valid/out_ready | qw qx qy qz bad_input
//
// One item enters per cycle while the output is not stalled. The pipeline has
// 2 + ROOT_W + NUM_W register stages (49 at Q1.14): one stage for trace, branch pick
// and numerators, one stage per root bit in the square-root pipeline, one stage per
// quotient bit in the three divider pipelines, and the output register.
// rst is synchronous and clears only the valid bits; no clearing pass.
// A stall at the output freezes every stage at once, so nothing is lost or repeated.
`default_nettype none
module rotation_matrix_to_quaternion (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [rmq_pkg::DW-1:0] m11,
  input  logic [rmq_pkg::DW-1:0] m12,
  input  logic [rmq_pkg::DW-1:0] m13,
  input  logic [rmq_pkg::DW-1:0] m21,
  input  logic [rmq_pkg::DW-1:0] m22,
  input  logic [rmq_pkg::DW-1:0] m23,
  input  logic [rmq_pkg::DW-1:0] m31,
  input  logic [rmq_pkg::DW-1:0] m32,
  input  logic [rmq_pkg::DW-1:0] m33,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [rmq_pkg::DW-1:0] qw,
  output logic [rmq_pkg::DW-1:0] qx,
  output logic [rmq_pkg::DW-1:0] qy,
  output logic [rmq_pkg::DW-1:0] qz,
  output logic                   bad_input
);
  import rmq_pkg::*;

  localparam logic signed [ARG_W-1:0] ONE = ARG_W'(1) << FRAC_BITS;

  // global advance: the output slot is empty or being drained
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------- front end: trace, branch, root argument, numerators
  logic signed [ARG_W-1:0] a11, a22, a33, tr, arg;
  logic signed [DW:0]      d3223, d1331, d2112, s1221, s1331, s2332;
  logic signed [DW:0]      nsel [3];
  logic [MAG_W-1:0]        nmag [3];
  logic [2:0]              nneg;
  branch_t                 br;
  logic                    bad;
  logic [RAD_W-1:0]        rad;

  assign a11 = ARG_W'(signed'(m11));
  assign a22 = ARG_W'(signed'(m22));
  assign a33 = ARG_W'(signed'(m33));
  assign tr  = a11 + a22 + a33;

  assign d3223 = {m32[DW-1], m32} - {m23[DW-1], m23};
  assign d1331 = {m13[DW-1], m13} - {m31[DW-1], m31};
  assign d2112 = {m21[DW-1], m21} - {m12[DW-1], m12};
  assign s1221 = {m12[DW-1], m12} + {m21[DW-1], m21};
  assign s1331 = {m13[DW-1], m13} + {m31[DW-1], m31};
  assign s2332 = {m23[DW-1], m23} + {m32[DW-1], m32};

  always_comb begin
    if (tr > 0) begin
      br  = BR_TRACE;
      arg = tr + ONE;
    end else if (a11 > a22 && a11 > a33) begin
      br  = BR_X;
      arg = ONE + a11 - a22 - a33;
    end else if (a22 > a33) begin
      br  = BR_Y;
      arg = ONE + a22 - a11 - a33;
    end else begin
      br  = BR_Z;
      arg = ONE + a33 - a11 - a22;
    end
    bad = (arg <= 0);
    rad = bad ? '0 : (RAD_W'(arg[ARG_W-2:0]) << FRAC_BITS);
  end

  // Numerators in the order of the non-root components (w, x, y, z skipping the root one).
  always_comb begin
    case (br)
      BR_TRACE: begin nsel[0] = d3223; nsel[1] = d1331; nsel[2] = d2112; end
      BR_X:     begin nsel[0] = d3223; nsel[1] = s1221; nsel[2] = s1331; end
      BR_Y:     begin nsel[0] = d1331; nsel[1] = s1221; nsel[2] = s2332; end
      BR_Z:     begin nsel[0] = d2112; nsel[1] = s1331; nsel[2] = s2332; end
      default:  begin nsel[0] = '0;    nsel[1] = '0;    nsel[2] = '0;    end
    endcase
  end

  // keep the full DW+1 bits: the most negative sum has magnitude 2^DW
  for (genvar i = 0; i < 3; i++) begin : g_mag
    logic [DW:0] negd;
    assign negd    = ~nsel[i] + (DW+1)'(1);
    assign nneg[i] = nsel[i][DW];
    assign nmag[i] = nneg[i] ? negd : nsel[i];
  end

  logic             s0_vld;
  logic [RAD_W-1:0] s0_rad;
  branch_t          s0_br;
  logic             s0_bad;
  logic [2:0]       s0_neg;
  logic [MAG_W-1:0] s0_mag [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_rad    <= rad;
      s0_br     <= br;
      s0_bad    <= bad;
      s0_neg    <= nneg;
      s0_mag[0] <= nmag[0];
      s0_mag[1] <= nmag[1];
      s0_mag[2] <= nmag[2];
    end
  end

  // ---------------- square-root pipeline, one root bit per stage
  logic             sq_vld  [ROOT_W];
  logic [RAD_W-1:0] sq_rad  [ROOT_W];
  logic [ROOT_W-1:0] sq_rem [ROOT_W];
  logic [ROOT_W-1:0] sq_root[ROOT_W];
  branch_t          sq_br   [ROOT_W];
  logic             sq_bad  [ROOT_W];
  logic [2:0]       sq_neg  [ROOT_W];
  logic [MAG_W-1:0] sq_mag0 [ROOT_W];
  logic [MAG_W-1:0] sq_mag1 [ROOT_W];
  logic [MAG_W-1:0] sq_mag2 [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    logic              c_vld;
    logic [RAD_W-1:0]  c_rad;
    logic [ROOT_W-1:0] c_rem;
    logic [ROOT_W-1:0] c_root;
    branch_t           c_br;
    logic              c_bad;
    logic [2:0]        c_neg;
    logic [MAG_W-1:0]  c_m0, c_m1, c_m2;
    logic [ROOT_W+1:0] rem_t, trial, rem_d;
    logic              ge;

    if (g == 0) begin : g_src_front
      assign c_vld  = s0_vld;
      assign c_rad  = s0_rad;
      assign c_rem  = '0;
      assign c_root = '0;
      assign c_br   = s0_br;
      assign c_bad  = s0_bad;
      assign c_neg  = s0_neg;
      assign c_m0   = s0_mag[0];
      assign c_m1   = s0_mag[1];
      assign c_m2   = s0_mag[2];
    end else begin : g_src_prev
      assign c_vld  = sq_vld[g-1];
      assign c_rad  = sq_rad[g-1];
      assign c_rem  = sq_rem[g-1];
      assign c_root = sq_root[g-1];
      assign c_br   = sq_br[g-1];
      assign c_bad  = sq_bad[g-1];
      assign c_neg  = sq_neg[g-1];
      assign c_m0   = sq_mag0[g-1];
      assign c_m1   = sq_mag1[g-1];
      assign c_m2   = sq_mag2[g-1];
    end

    assign rem_t = {c_rem, c_rad[RAD_W-1:RAD_W-2]};
    assign trial = {c_root, 2'b01};
    assign rem_d = rem_t - trial;
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[g] <= 1'b0;
      end else if (en) begin
        sq_vld[g] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[g]  <= ge ? rem_d[ROOT_W-1:0] : rem_t[ROOT_W-1:0];
        sq_root[g] <= {c_root[ROOT_W-2:0], ge};
        sq_rad[g]  <= c_rad << 2;
        sq_br[g]   <= c_br;
        sq_bad[g]  <= c_bad;
        sq_neg[g]  <= c_neg;
        sq_mag0[g] <= c_m0;
        sq_mag1[g] <= c_m1;
        sq_mag2[g] <= c_m2;
      end
    end
  end

  // ---------------- divide by S = 2r, three lanes
  logic [ROOT_W-1:0] root_f;
  logic [S_W-1:0]    s_den;
  logic [DW-1:0]     half_r;
  logic [DW-1:0]     qd [3];

  assign root_f = sq_root[ROOT_W-1];
  assign s_den  = {root_f, 1'b0};
  assign half_r = sat_mag(NUM_W'(root_f >> 1), 1'b0);

  rmq_div_pipe u_div0 (
    .clk (clk), .en (en),
    .num ({sq_mag0[ROOT_W-1], FRAC_BITS'(0)}),
    .den (s_den), .neg (sq_neg[ROOT_W-1][0]), .q (qd[0])
  );
  rmq_div_pipe u_div1 (
    .clk (clk), .en (en),
    .num ({sq_mag1[ROOT_W-1], FRAC_BITS'(0)}),
    .den (s_den), .neg (sq_neg[ROOT_W-1][1]), .q (qd[1])
  );
  rmq_div_pipe u_div2 (
    .clk (clk), .en (en),
    .num ({sq_mag2[ROOT_W-1], FRAC_BITS'(0)}),
    .den (s_den), .neg (sq_neg[ROOT_W-1][2]), .q (qd[2])
  );

  // sideband that rides beside the dividers
  logic          dv_vld  [NUM_W];
  branch_t       dv_br   [NUM_W];
  logic          dv_bad  [NUM_W];
  logic [DW-1:0] dv_half [NUM_W];

  for (genvar g = 0; g < NUM_W; g++) begin : g_side
    logic          c_vld;
    branch_t       c_br;
    logic          c_bad;
    logic [DW-1:0] c_half;

    if (g == 0) begin : g_src_sqrt
      assign c_vld  = sq_vld[ROOT_W-1];
      assign c_br   = sq_br[ROOT_W-1];
      assign c_bad  = sq_bad[ROOT_W-1];
      assign c_half = half_r;
    end else begin : g_src_prev
      assign c_vld  = dv_vld[g-1];
      assign c_br   = dv_br[g-1];
      assign c_bad  = dv_bad[g-1];
      assign c_half = dv_half[g-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[g] <= 1'b0;
      end else if (en) begin
        dv_vld[g] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_br[g]   <= c_br;
        dv_bad[g]  <= c_bad;
        dv_half[g] <= c_half;
      end
    end
  end

  // ---------------- output register: route root half and quotients, zero on bad
  branch_t       f_br;
  logic          f_bad;
  logic [DW-1:0] f_half;
  logic [DW-1:0] nw, nx, ny, nz;
  branch_t       out_br;

  assign f_br   = dv_br[NUM_W-1];
  assign f_bad  = dv_bad[NUM_W-1];
  assign f_half = dv_half[NUM_W-1];

  always_comb begin
    case (f_br)
      BR_TRACE: begin nw = f_half; nx = qd[0];  ny = qd[1];  nz = qd[2];  end
      BR_X:     begin nw = qd[0];  nx = f_half; ny = qd[1];  nz = qd[2];  end
      BR_Y:     begin nw = qd[0];  nx = qd[1];  ny = f_half; nz = qd[2];  end
      BR_Z:     begin nw = qd[0];  nx = qd[1];  ny = qd[2];  nz = f_half; end
      default:  begin nw = '0;     nx = '0;     ny = '0;     nz = '0;     end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_vld[NUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qw        <= f_bad ? '0 : nw;
      qx        <= f_bad ? '0 : nx;
      qy        <= f_bad ? '0 : ny;
      qz        <= f_bad ? '0 : nz;
      bad_input <= f_bad;
      out_br    <= f_br;
    end
  end

`include "rotation_matrix_to_quaternion_assert.svh"

  `RMQ_ASSERT_IMP(a_bad_zero, out_valid && bad_input, qw == '0 && qx == '0 && qy == '0 && qz == '0, "bad item with nonzero quaternion")
  `RMQ_ASSERT_IMP(a_root_nonneg, out_valid && !bad_input && out_br == BR_TRACE, !qw[DW-1], "trace branch gave negative w")
  `RMQ_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, s0_vld, "accepted item missing from front stage")
  `RMQ_ASSERT_NEXT(a_stall_holds, !en, $stable(s0_vld) && $stable(dv_vld[NUM_W-1]) && $stable(out_valid), "pipeline moved during stall")

endmodule
`default_nettype wire

/* design/rmq_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, signed saturated result.
`default_nettype none
module rmq_div_pipe (
  input  logic                      clk,
  input  logic                      en,
  input  logic [rmq_pkg::NUM_W-1:0] num,
  input  logic [rmq_pkg::S_W-1:0]   den,
  input  logic                      neg,
  output logic [rmq_pkg::DW-1:0]    q
);
  import rmq_pkg::*;

  logic [NUM_W-1:0] p_num [NUM_W];
  logic [S_W-1:0]   p_rem [NUM_W];
  logic [NUM_W-1:0] p_q   [NUM_W];
  logic [S_W-1:0]   p_den [NUM_W];
  logic             p_neg [NUM_W];

  for (genvar g = 0; g < NUM_W; g++) begin : g_stage
    logic [NUM_W-1:0] c_num;
    logic [S_W-1:0]   c_rem;
    logic [NUM_W-1:0] c_q;
    logic [S_W-1:0]   c_den;
    logic             c_neg;
    logic [S_W:0]     rem_t;
    logic [S_W:0]     rem_d;
    logic             ge;

    if (g == 0) begin : g_src_in
      assign c_num = num;
      assign c_rem = '0;
      assign c_q   = '0;
      assign c_den = den;
      assign c_neg = neg;
    end else begin : g_src_prev
      assign c_num = p_num[g-1];
      assign c_rem = p_rem[g-1];
      assign c_q   = p_q[g-1];
      assign c_den = p_den[g-1];
      assign c_neg = p_neg[g-1];
    end

    assign rem_t = {c_rem, c_num[NUM_W-1]};
    assign rem_d = rem_t - {1'b0, c_den};
    assign ge    = (rem_t >= {1'b0, c_den});

    always_ff @(posedge clk) begin
      if (en) begin
        p_rem[g] <= ge ? rem_d[S_W-1:0] : rem_t[S_W-1:0];
        p_q[g]   <= {c_q[NUM_W-2:0], ge};
        p_num[g] <= c_num << 1;
        p_den[g] <= c_den;
        p_neg[g] <= c_neg;
      end
    end
  end

  assign q = sat_mag(p_q[NUM_W-1], p_neg[NUM_W-1]);

endmodule
`default_nettype wire
